FILE: hw/rtl/fvp_pkg.sv
// Shared widths, register indexes and reset values of the flywheel velocity controller.
`default_nettype none

package fvp_pkg;

	localparam int SPEED_W  = 15;
	localparam int TIME_W   = 32;
	localparam int CFG_W    = 16;
	localparam int OFFSET_W = 7;
	localparam int DRIVE_W  = 8;
	localparam int ERR_W    = 17;
	localparam int DE_W     = 18;
	localparam int SUM_W    = 49;
	localparam int IMAG_W   = 47;
	localparam int DMAG_W   = 35;
	localparam int PMAG_W   = 33;
	localparam int IDX_W    = 3;

	// The integral term magnitude is capped at two to this power.
	localparam int ITERM_CAP_LOG = 46;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN     = 3'd1,
		REG_DERIV_GAIN     = 3'd2,
		REG_LEAK_FACTOR    = 3'd3,
		REG_FF_SLOPE       = 3'd4,
		REG_FF_OFFSET      = 3'd5,
		REG_BOOST_FRACTION = 3'd6
	} reg_idx_t;

	localparam logic [CFG_W-1:0]    LEAK_RESET   = 16'd56496;
	localparam logic [CFG_W-1:0]    SLOPE_RESET  = 16'd14746;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 7'd10;
	localparam logic [CFG_W-1:0]    BOOST_RESET  = 16'd58982;

endpackage

`default_nettype wire

FILE: hw/rtl/fvp_if.sv
// Valid/ready channel interfaces for speed samples and drive results.
`default_nettype none

interface fvp_sample_if;
	import fvp_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SPEED_W-1:0]  target_speed;
	logic signed [SPEED_W-1:0]  measured_speed;
	logic        [TIME_W-1:0]   now_ms;
	modport source (output valid, target_speed, measured_speed, now_ms, input ready);
	modport sink   (input valid, target_speed, measured_speed, now_ms, output ready);
endinterface

interface fvp_result_if;
	import fvp_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [DRIVE_W-1:0]  drive;
	logic                       boosted;
	logic                       saturated;
	modport source (output valid, drive, boosted, saturated, input ready);
	modport sink   (input valid, drive, boosted, saturated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/flywheel_velocity_pid_core.sv
// Flywheel velocity PID controller with feedforward, low-speed boost and drive saturation.
//
// Usage: one speed sample (target, measured, time in ms) is taken on the sample channel
// whenever the block is idle; it answers with exactly one drive result on the result
// channel. Gains and constants are written through the cfg_we/cfg_index/cfg_wdata port
// while no sample is in flight.
// All products go through one shift-and-add multiplier that retires one multiplier bit a
// cycle, and all quotients through one restoring divider that retires one quotient bit a
// cycle. A target at or below zero takes 1 multiply and 1 divide; a positive target takes
// 7 multiplies and 2 divides, of which a zero elapsed time skips one multiply and divide,
// and an integral magnitude above the cap skips the integral multiply and divide.
// One sample is processed at a time; ready is high only while the sequencer idles.
// The result sits in an output register, so a stalled receiver does not hold up the next
// sample until the following result is done; the sequencer then waits for the register.
// Reset clears the integral, the previous error and time, and loads the default
// configuration; the block is ready in the first cycle after reset.
`default_nettype none

module flywheel_velocity_pid_core #(
	parameter int INTEGRAL_WIDTH = 48,
	parameter int FULL_SPEED_RPM = 600,
	parameter int MAX_DRIVE      = 127
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	fvp_sample_if.sink                      sample,
	fvp_result_if.source                    result,
	input  wire logic                       cfg_we,
	input  wire logic [fvp_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [fvp_pkg::CFG_W-1:0]  cfg_wdata
);
	import fvp_pkg::*;

	localparam int IW = INTEGRAL_WIDTH;
	localparam int PW = IW + 32;
	localparam int SW = PW + 1;
	localparam int CW = $clog2(PW);
	localparam int MW = 37;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_OL_MUL = 16'h0002,
		S_OL_DIV = 16'h0004,
		S_LK_MUL = 16'h0008,
		S_EE_MUL = 16'h0010,
		S_IG_SET = 16'h0020,
		S_IG_MUL = 16'h0040,
		S_IG_DIV = 16'h0080,
		S_DD_SET = 16'h0100,
		S_DD_MUL = 16'h0200,
		S_DD_DIV = 16'h0400,
		S_PG_MUL = 16'h0800,
		S_FF_MUL = 16'h1000,
		S_BF_MUL = 16'h2000,
		S_FIN    = 16'h4000,
		S_OUT    = 16'h8000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CFG_W-1:0]    pg_q, ig_q, dg_q, leak_q, slope_q, bf_q;
	logic [OFFSET_W-1:0] off_q;

	// Controller state.
	logic [IW-1:0]     acc_q;
	logic [ERR_W-1:0]  perr_q;
	logic [TIME_W-1:0] ptime_q;

	// Per-sample working registers.
	logic [SPEED_W-1:0] tgt_q, meas_q;
	logic [TIME_W-1:0]  now_q, elapsed_q;
	logic [ERR_W-1:0]   err_q;
	logic [IMAG_W-1:0]  imag_q;
	logic [DMAG_W-1:0]  dmag_q;
	logic [SUM_W-1:0]   sum_q;
	logic               boost_q;
	logic [DRIVE_W-1:0] res_drive_q;
	logic               res_boost_q, res_sat_q;

	// Output register.
	logic               out_valid_q;
	logic [DRIVE_W-1:0] drive_q;
	logic               boosted_q, saturated_q;

	// Serial multiplier and divider.
	logic [CW-1:0]  cnt_q;
	logic [IW-1:0]  mcand_q;
	logic [31:0]    mplier_q;
	logic [PW-1:0]  prod_q;
	logic [PW-1:0]  dvd_q;
	logic [31:0]    rem_q;
	logic [31:0]    dvs_q;

	logic [PW-1:0]  prod_nxt;
	logic [32:0]    div_t;
	logic           div_ge;
	logic [32:0]    div_sub;
	logic [31:0]    rem_nxt;
	logic [PW-1:0]  quot_nxt;
	logic           is_mul, is_div, mul_last, div_last;

	assign prod_nxt = {prod_q[PW-2:0], 1'b0} + (mplier_q[31] ? PW'(mcand_q) : '0);
	assign div_t    = {rem_q, dvd_q[PW-1]};
	assign div_ge   = div_t >= {1'b0, dvs_q};
	assign div_sub  = div_t - {1'b0, dvs_q};
	assign rem_nxt  = div_ge ? div_sub[31:0] : div_t[31:0];
	assign quot_nxt = {dvd_q[PW-2:0], div_ge};

	assign is_mul = (state_q == S_OL_MUL) || (state_q == S_LK_MUL) || (state_q == S_EE_MUL)
		|| (state_q == S_IG_MUL) || (state_q == S_DD_MUL) || (state_q == S_PG_MUL)
		|| (state_q == S_FF_MUL) || (state_q == S_BF_MUL);
	assign is_div = (state_q == S_OL_DIV) || (state_q == S_IG_DIV) || (state_q == S_DD_DIV);
	assign mul_last = cnt_q == CW'(31);
	assign div_last = cnt_q == CW'(PW - 1);

	// Values derived from the incoming sample.
	logic               in_acc;
	logic [SPEED_W-1:0] in_tmag;
	logic [ERR_W-1:0]   in_err;

	assign in_acc  = sample.valid && sample.ready;
	assign in_tmag = sample.target_speed[SPEED_W-1] ? -sample.target_speed : sample.target_speed;
	assign in_err  = {{2{sample.target_speed[SPEED_W-1]}}, sample.target_speed}
		- {{2{sample.measured_speed[SPEED_W-1]}}, sample.measured_speed};

	// Signs and magnitudes of the stored values.
	logic             acc_neg, err_neg, de_neg;
	logic [IW-1:0]    acc_mag;
	logic [ERR_W-1:0] err_mag;
	logic [DE_W-1:0]  de, de_mag;

	assign acc_neg = acc_q[IW-1];
	assign acc_mag = acc_neg ? -acc_q : acc_q;
	assign err_neg = err_q[ERR_W-1];
	assign err_mag = err_neg ? -err_q : err_q;
	assign de      = {err_q[ERR_W-1], err_q} - {perr_q[ERR_W-1], perr_q};
	assign de_neg  = de[DE_W-1];
	assign de_mag  = de_neg ? -de : de;

	// Leaked integral: magnitude times the leak factor over 2^16, sign restored.
	logic [IW-1:0] lk_mag, lk_val;
	assign lk_mag = prod_nxt[IW+15:16];
	assign lk_val = acc_neg ? -lk_mag : lk_mag;

	// Integral plus error times elapsed time, saturated to the integral range.
	logic [SW-1:0] ee_s, isum;
	logic          isum_fits;
	logic [IW-1:0] isum_sat;
	assign ee_s      = err_neg ? -SW'(prod_nxt) : SW'(prod_nxt);
	assign isum      = {{(SW-IW){acc_q[IW-1]}}, acc_q} + ee_s;
	assign isum_fits = (isum[SW-1:IW-1] == '0) || (isum[SW-1:IW-1] == '1);
	assign isum_sat  = isum_fits ? isum[IW-1:0]
		: (isum[SW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}});

	// Integral term cap.
	logic [PW-1:0]     cap_pw;
	logic [IMAG_W-1:0] cap_m;
	assign cap_pw = PW'(1) << ITERM_CAP_LOG;
	assign cap_m  = IMAG_W'(1) << ITERM_CAP_LOG;

	// Closed-loop sum of the gain terms and the feedforward offset.
	logic [SUM_W-1:0] p_s, i_s, d_s, o_s;
	assign p_s = err_neg ? -SUM_W'(prod_nxt[PMAG_W-1:0]) : SUM_W'(prod_nxt[PMAG_W-1:0]);
	assign i_s = acc_neg ? -SUM_W'(imag_q) : SUM_W'(imag_q);
	assign d_s = de_neg ? -SUM_W'(dmag_q) : SUM_W'(dmag_q);
	assign o_s = SUM_W'(off_q) << 12;

	// Boost compare: measured times 2^16 against boost fraction times target.
	logic signed [31:0] meas_sh, bf_prod;
	assign meas_sh = {meas_q[SPEED_W-1], meas_q, 16'b0};
	assign bf_prod = $signed({1'b0, prod_nxt[30:0]});

	// Final drive from the sum, truncated toward zero and clipped.
	logic             s_neg, s_sat;
	logic [SUM_W-1:0] s_mag;
	logic [MW-1:0]    s_q, s_clip;
	assign s_neg  = sum_q[SUM_W-1];
	assign s_mag  = s_neg ? -sum_q : sum_q;
	assign s_q    = s_mag[SUM_W-1:12];
	assign s_sat  = s_q > MW'(MAX_DRIVE);
	assign s_clip = s_sat ? MW'(MAX_DRIVE) : s_q;

	// Open-loop drive, clipped.
	logic          ol_sat;
	logic [PW-1:0] ol_clip;
	assign ol_sat  = quot_nxt > PW'(MAX_DRIVE);
	assign ol_clip = ol_sat ? PW'(MAX_DRIVE) : quot_nxt;

	assign sample.ready = state_q == S_IDLE;
	assign result.valid     = out_valid_q;
	assign result.drive     = drive_q;
	assign result.boosted   = boosted_q;
	assign result.saturated = saturated_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_q    <= '0;
			ig_q    <= '0;
			dg_q    <= '0;
			leak_q  <= LEAK_RESET;
			slope_q <= SLOPE_RESET;
			off_q   <= OFFSET_RESET;
			bf_q    <= BOOST_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:      pg_q    <= cfg_wdata;
				REG_INTEG_GAIN:     ig_q    <= cfg_wdata;
				REG_DERIV_GAIN:     dg_q    <= cfg_wdata;
				REG_LEAK_FACTOR:    leak_q  <= cfg_wdata;
				REG_FF_SLOPE:       slope_q <= cfg_wdata;
				REG_FF_OFFSET:      off_q   <= cfg_wdata[OFFSET_W-1:0];
				REG_BOOST_FRACTION: bf_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer with controller state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			perr_q      <= '0;
			ptime_q     <= '0;
			cnt_q       <= '0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			// Advance the running unit by one bit.
			if (is_mul) begin
				prod_q   <= prod_nxt;
				mplier_q <= {mplier_q[30:0], 1'b0};
				cnt_q    <= cnt_q + CW'(1);
			end
			if (is_div) begin
				dvd_q <= quot_nxt;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q + CW'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						tgt_q     <= sample.target_speed;
						meas_q    <= sample.measured_speed;
						now_q     <= sample.now_ms;
						elapsed_q <= sample.now_ms - ptime_q;
						err_q     <= in_err;
						cnt_q     <= '0;
						prod_q    <= '0;
						if (sample.target_speed[SPEED_W-1] || sample.target_speed == '0) begin
							mcand_q  <= IW'(in_tmag);
							mplier_q <= 32'(MAX_DRIVE);
							state_q  <= S_OL_MUL;
						end else begin
							mcand_q  <= acc_mag;
							mplier_q <= {16'b0, leak_q};
							state_q  <= S_LK_MUL;
						end
					end
				end
				S_OL_MUL: begin
					if (mul_last) begin
						dvd_q   <= prod_nxt;
						rem_q   <= '0;
						dvs_q   <= 32'(FULL_SPEED_RPM * 16);
						cnt_q   <= '0;
						state_q <= S_OL_DIV;
					end
				end
				S_OL_DIV: begin
					if (div_last) begin
						res_drive_q <= tgt_q[SPEED_W-1] ? -ol_clip[DRIVE_W-1:0]
							: ol_clip[DRIVE_W-1:0];
						res_boost_q <= 1'b0;
						res_sat_q   <= ol_sat;
						acc_q       <= '0;
						ptime_q     <= now_q;
						state_q     <= S_OUT;
					end
				end
				S_LK_MUL: begin
					if (mul_last) begin
						acc_q    <= lk_val;
						mcand_q  <= IW'(err_mag);
						mplier_q <= elapsed_q;
						prod_q   <= '0;
						cnt_q    <= '0;
						state_q  <= S_EE_MUL;
					end
				end
				S_EE_MUL: begin
					if (mul_last) begin
						acc_q   <= isum_sat;
						state_q <= S_IG_SET;
					end
				end
				S_IG_SET: begin
					if (PW'(acc_mag) > cap_pw) begin
						imag_q  <= (ig_q != '0) ? cap_m : '0;
						state_q <= S_DD_SET;
					end else begin
						mcand_q  <= acc_mag;
						mplier_q <= {16'b0, ig_q};
						prod_q   <= '0;
						cnt_q    <= '0;
						state_q  <= S_IG_MUL;
					end
				end
				S_IG_MUL: begin
					if (mul_last) begin
						dvd_q   <= prod_nxt;
						rem_q   <= '0;
						dvs_q   <= 32'd1000;
						cnt_q   <= '0;
						state_q <= S_IG_DIV;
					end
				end
				S_IG_DIV: begin
					if (div_last) begin
						imag_q  <= (quot_nxt > cap_pw) ? cap_m : quot_nxt[IMAG_W-1:0];
						state_q <= S_DD_SET;
					end
				end
				S_DD_SET: begin
					prod_q <= '0;
					cnt_q  <= '0;
					if (elapsed_q == '0) begin
						dmag_q   <= '0;
						mcand_q  <= IW'(err_mag);
						mplier_q <= {16'b0, pg_q};
						state_q  <= S_PG_MUL;
					end else begin
						mcand_q  <= IW'(de_mag);
						mplier_q <= {16'b0, dg_q};
						state_q  <= S_DD_MUL;
					end
				end
				S_DD_MUL: begin
					if (mul_last) begin
						dvd_q   <= prod_nxt;
						rem_q   <= '0;
						dvs_q   <= elapsed_q;
						cnt_q   <= '0;
						state_q <= S_DD_DIV;
					end
				end
				S_DD_DIV: begin
					if (div_last) begin
						dmag_q   <= quot_nxt[DMAG_W-1:0];
						mcand_q  <= IW'(err_mag);
						mplier_q <= {16'b0, pg_q};
						prod_q   <= '0;
						cnt_q    <= '0;
						state_q  <= S_PG_MUL;
					end
				end
				S_PG_MUL: begin
					if (mul_last) begin
						sum_q    <= p_s + i_s + d_s + o_s;
						mcand_q  <= IW'(tgt_q);
						mplier_q <= {16'b0, slope_q};
						prod_q   <= '0;
						cnt_q    <= '0;
						state_q  <= S_FF_MUL;
					end
				end
				S_FF_MUL: begin
					if (mul_last) begin
						sum_q    <= sum_q + SUM_W'(prod_nxt[30:8]);
						mcand_q  <= IW'(tgt_q);
						mplier_q <= {16'b0, bf_q};
						prod_q   <= '0;
						cnt_q    <= '0;
						state_q  <= S_BF_MUL;
					end
				end
				S_BF_MUL: begin
					if (mul_last) begin
						boost_q <= meas_sh < bf_prod;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (boost_q) begin
						res_drive_q <= DRIVE_W'(MAX_DRIVE);
						res_sat_q   <= 1'b0;
					end else begin
						res_drive_q <= s_neg ? -s_clip[DRIVE_W-1:0] : s_clip[DRIVE_W-1:0];
						res_sat_q   <= s_sat;
					end
					res_boost_q <= boost_q;
					perr_q      <= err_q;
					ptime_q     <= now_q;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					// Hand the result to the output register once it is free.
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						drive_q     <= res_drive_q;
						boosted_q   <= res_boost_q;
						saturated_q <= res_sat_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/fvp_checker.sv
// Port-level checker for the flywheel velocity controller and its bind statement.
`default_nettype none

module fvp_checker #(
	parameter int MAX_DRIVE = 127
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_drive,
	input wire logic       out_boosted,
	input wire logic       out_saturated
);

	// A sample occupies the sequencer, so no second transfer follows at once.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted back to back");

	// A boosted result is full forward drive and never marked saturated.
	a_boost_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_boosted |-> out_drive == 8'(MAX_DRIVE) && !out_saturated)
		else $error("boosted result without full drive");

	// A saturated result sits at one of the two limits.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_saturated
		|-> (out_drive == 8'(MAX_DRIVE)) || (out_drive == 8'(-MAX_DRIVE)))
		else $error("saturated result off the limits");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_drive)
		&& $stable(out_boosted) && $stable(out_saturated))
		else $error("stalled result changed");

endmodule

bind flywheel_velocity_pid_core fvp_checker #(.MAX_DRIVE(MAX_DRIVE)) u_fvp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample.valid),
	.in_ready      (sample.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.out_drive     (result.drive),
	.out_boosted   (result.boosted),
	.out_saturated (result.saturated)
);

`default_nettype wire
